@@ design/tmk_pkg.sv @@
package tmk_pkg;

  // fixed point format of every intermediate value
  localparam int DATA_WIDTH    = 32;
  localparam int FRAC_BITS     = 24;
  localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
  localparam int QUOT_WIDTH    = PROD_WIDTH - FRAC_BITS;

  // field and register widths
  localparam int RATIO_WIDTH   = 31;
  localparam int TILT_WIDTH    = 26;
  localparam int ORDER_WIDTH   = 4;
  localparam int ORD_EXT_WIDTH = ORDER_WIDTH + 1;
  localparam int CFG_IDX_WIDTH = 3;

  // default highest multipole order
  localparam int MAX_ORDER_DEF = 10;

  // register reset values
  localparam logic [ORDER_WIDTH-1:0] POLE_ORDER_RST = ORDER_WIDTH'(2);
  localparam logic [TILT_WIDTH-1:0]  TILT_COS_RST   = TILT_WIDTH'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_STRENGTH_COS,
    CFG_STRENGTH_SIN,
    CFG_OFFSET_X,
    CFG_OFFSET_Y,
    CFG_TILT_COS,
    CFG_TILT_SIN,
    CFG_POLE_ORDER
  } cfg_reg_e;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam data_t ONE_Q    = data_t'(1) <<< FRAC_BITS;

  // value with its clip flag
  typedef struct packed {
    logic  clip;
    data_t val;
  } sat_t;

  // particle values that ride along the rotation stages
  typedef struct packed {
    data_t                  sx;
    data_t                  sy;
    logic [RATIO_WIDTH-1:0] ratio;
  } carry_t;

  // payload handed from cell to cell
  typedef struct packed {
    logic                   sat;
    data_t                  cr;
    data_t                  ci;
    data_t                  xr;
    data_t                  yr;
    data_t                  sx;
    data_t                  sy;
    logic [RATIO_WIDTH-1:0] ratio;
  } pow_t;

  // finished kick
  typedef struct packed {
    logic  sat;
    data_t nx;
    data_t ny;
  } res_t;

  // round a full product to FRAC_BITS, half away from zero, then clip
  function automatic sat_t rnd_clip(prod_t p);
    prod_t                        bias;
    prod_t                        sum;
    logic signed [QUOT_WIDTH-1:0] q;
    logic [QUOT_WIDTH-DATA_WIDTH:0] hi;
    logic                         ok;
    sat_t                         r;
    bias = prod_t'(1) <<< (FRAC_BITS - 1);
    if (p[PROD_WIDTH-1]) begin
      bias = bias - prod_t'(1);
    end
    sum    = p + bias;
    q      = sum[PROD_WIDTH-1:FRAC_BITS];
    hi     = q[QUOT_WIDTH-1:DATA_WIDTH-1];
    ok     = (&hi) | ~(|hi);
    r.clip = ~ok;
    if (ok) begin
      r.val = q[DATA_WIDTH-1:0];
    end else if (q[QUOT_WIDTH-1]) begin
      r.val = DATA_MIN;
    end else begin
      r.val = DATA_MAX;
    end
    return r;
  endfunction

  // saturating add or subtract
  function automatic sat_t add_sat(data_t a, data_t b, logic sub);
    logic [DATA_WIDTH:0] s;
    sat_t                r;
    if (sub) begin
      s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    end else begin
      s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    end
    r.clip = s[DATA_WIDTH] ^ s[DATA_WIDTH-1];
    if (!r.clip) begin
      r.val = s[DATA_WIDTH-1:0];
    end else if (s[DATA_WIDTH]) begin
      r.val = DATA_MIN;
    end else begin
      r.val = DATA_MAX;
    end
    return r;
  endfunction

endpackage

@@ design/tmk_rotate.sv @@
module tmk_rotate
  import tmk_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  data_t                  pos_x_i,
  input  data_t                  pos_y_i,
  input  carry_t                 carry_i,
  input  data_t                  offset_x_i,
  input  data_t                  offset_y_i,
  input  logic [TILT_WIDTH-1:0]  tilt_cos_i,
  input  logic [TILT_WIDTH-1:0]  tilt_sin_i,
  output logic                   vld_o,
  output pow_t                   pl_o
);

  logic [3:0] vld_q;

  data_t  tc, ts;
  sat_t   dx_d, dy_d;
  data_t  dx_q, dy_q;
  logic   sat1_q;
  carry_t car1_q, car2_q, car3_q;
  prod_t  p_xc_q, p_ys_q, p_yc_q, p_xs_q;
  logic   sat2_q;
  sat_t   r_xc, r_ys, r_yc, r_xs;
  data_t  r_xc_q, r_ys_q, r_yc_q, r_xs_q;
  logic   sat3_q;
  sat_t   xr_d, yr_d;
  pow_t   pl_q;

  assign tc = data_t'(signed'(tilt_cos_i));
  assign ts = data_t'(signed'(tilt_sin_i));

  // valid bits of the four stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  // stage 1: remove element offset
  assign dx_d = add_sat(pos_x_i, offset_x_i, 1'b1);
  assign dy_d = add_sat(pos_y_i, offset_y_i, 1'b1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d.val;
      dy_q   <= dy_d.val;
      sat1_q <= dx_d.clip | dy_d.clip;
      car1_q <= carry_i;
    end
  end

  // stage 2: tilt products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_xc_q <= dx_q * tc;
      p_ys_q <= dy_q * ts;
      p_yc_q <= dy_q * tc;
      p_xs_q <= dx_q * ts;
      sat2_q <= sat1_q;
      car2_q <= car1_q;
    end
  end

  // stage 3: round and clip products
  assign r_xc = rnd_clip(p_xc_q);
  assign r_ys = rnd_clip(p_ys_q);
  assign r_yc = rnd_clip(p_yc_q);
  assign r_xs = rnd_clip(p_xs_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_xc_q <= r_xc.val;
      r_ys_q <= r_ys.val;
      r_yc_q <= r_yc.val;
      r_xs_q <= r_xs.val;
      sat3_q <= sat2_q | r_xc.clip | r_ys.clip | r_yc.clip | r_xs.clip;
      car3_q <= car2_q;
    end
  end

  // stage 4: rotated position, power starts at one
  assign xr_d = add_sat(r_xc_q, r_ys_q, 1'b0);
  assign yr_d = add_sat(r_yc_q, r_xs_q, 1'b1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q.sat   <= sat3_q | xr_d.clip | yr_d.clip;
      pl_q.cr    <= ONE_Q;
      pl_q.ci    <= '0;
      pl_q.xr    <= xr_d.val;
      pl_q.yr    <= yr_d.val;
      pl_q.sx    <= car3_q.sx;
      pl_q.sy    <= car3_q.sy;
      pl_q.ratio <= car3_q.ratio;
    end
  end

  assign vld_o = vld_q[3];
  assign pl_o  = pl_q;

endmodule

@@ design/tmk_pow_cell.sv @@
module tmk_pow_cell
  import tmk_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic act_i,
  input  logic vld_i,
  input  pow_t pl_i,
  output logic vld_o,
  output pow_t pl_o
);

  logic [2:0] vld_q;

  prod_t p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  pow_t  pl1_q, pl2_q, pl3_q;
  sat_t  r_rr, r_ii, r_ri, r_ir;
  data_t r_rr_q, r_ii_q, r_ri_q, r_ir_q;
  logic  clip2_q;
  sat_t  cr_d, ci_d;
  pow_t  pl3_d;

  // valid bits of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // stage 1: complex product terms of power times position
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_rr_q <= pl_i.cr * pl_i.xr;
      p_ii_q <= pl_i.ci * pl_i.yr;
      p_ri_q <= pl_i.cr * pl_i.yr;
      p_ir_q <= pl_i.ci * pl_i.xr;
      pl1_q  <= pl_i;
    end
  end

  // stage 2: round and clip
  assign r_rr = rnd_clip(p_rr_q);
  assign r_ii = rnd_clip(p_ii_q);
  assign r_ri = rnd_clip(p_ri_q);
  assign r_ir = rnd_clip(p_ir_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_rr_q  <= r_rr.val;
      r_ii_q  <= r_ii.val;
      r_ri_q  <= r_ri.val;
      r_ir_q  <= r_ir.val;
      clip2_q <= r_rr.clip | r_ii.clip | r_ri.clip | r_ir.clip;
      pl2_q   <= pl1_q;
    end
  end

  // stage 3: combine, or pass the power on untouched above the order
  assign cr_d = add_sat(r_rr_q, r_ii_q, 1'b1);
  assign ci_d = add_sat(r_ri_q, r_ir_q, 1'b0);

  always_comb begin
    pl3_d = pl2_q;
    if (act_i) begin
      pl3_d.cr  = cr_d.val;
      pl3_d.ci  = ci_d.val;
      pl3_d.sat = pl2_q.sat | clip2_q | cr_d.clip | ci_d.clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl3_q <= pl3_d;
    end
  end

  assign vld_o = vld_q[2];
  assign pl_o  = pl3_q;

endmodule

@@ design/tmk_kick.sv @@
module tmk_kick
  import tmk_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  pow_t  pl_i,
  input  data_t strength_cos_i,
  input  data_t strength_sin_i,
  output logic  vld_o,
  output res_t  res_o
);

  logic [5:0] vld_q;

  prod_t  p_cr_q, p_si_q, p_sr_q, p_ci_q;
  carry_t car1_q, car2_q, car3_q, car4_q, car5_q;
  logic   sat1_q, sat2_q, sat3_q, sat4_q, sat5_q;
  sat_t   r_cr, r_si, r_sr, r_ci;
  data_t  r_cr_q, r_si_q, r_sr_q, r_ci_q;
  sat_t   ax_d, ay_d;
  data_t  ax_q, ay_q;
  data_t  ratio;
  prod_t  p_kx_q, p_ky_q;
  sat_t   r_kx, r_ky;
  data_t  kx_q, ky_q;
  sat_t   nx_d, ny_d;
  res_t   res_q;

  // valid bits of the six stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  // stage 1: strength products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_cr_q       <= strength_cos_i * pl_i.cr;
      p_si_q       <= strength_sin_i * pl_i.ci;
      p_sr_q       <= strength_sin_i * pl_i.cr;
      p_ci_q       <= strength_cos_i * pl_i.ci;
      sat1_q       <= pl_i.sat;
      car1_q.sx    <= pl_i.sx;
      car1_q.sy    <= pl_i.sy;
      car1_q.ratio <= pl_i.ratio;
    end
  end

  // stage 2: round and clip
  assign r_cr = rnd_clip(p_cr_q);
  assign r_si = rnd_clip(p_si_q);
  assign r_sr = rnd_clip(p_sr_q);
  assign r_ci = rnd_clip(p_ci_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_cr_q <= r_cr.val;
      r_si_q <= r_si.val;
      r_sr_q <= r_sr.val;
      r_ci_q <= r_ci.val;
      sat2_q <= sat1_q | r_cr.clip | r_si.clip | r_sr.clip | r_ci.clip;
      car2_q <= car1_q;
    end
  end

  // stage 3: kick before momentum scaling
  assign ax_d = add_sat(r_cr_q, r_si_q, 1'b0);
  assign ay_d = add_sat(r_sr_q, r_ci_q, 1'b1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= ax_d.val;
      ay_q   <= ay_d.val;
      sat3_q <= sat2_q | ax_d.clip | ay_d.clip;
      car3_q <= car2_q;
    end
  end

  // stage 4: momentum ratio products
  assign ratio = data_t'({1'b0, car3_q.ratio});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_kx_q <= ratio * ax_q;
      p_ky_q <= ratio * ay_q;
      sat4_q <= sat3_q;
      car4_q <= car3_q;
    end
  end

  // stage 5: round and clip
  assign r_kx = rnd_clip(p_kx_q);
  assign r_ky = rnd_clip(p_ky_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kx_q   <= r_kx.val;
      ky_q   <= r_ky.val;
      sat5_q <= sat4_q | r_kx.clip | r_ky.clip;
      car5_q <= car4_q;
    end
  end

  // stage 6: add kick to slopes
  assign nx_d = add_sat(car5_q.sx, kx_q, 1'b0);
  assign ny_d = add_sat(car5_q.sy, ky_q, 1'b0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.nx  <= nx_d.val;
      res_q.ny  <= ny_d.val;
      res_q.sat <= sat5_q | nx_d.clip | ny_d.clip;
    end
  end

  assign vld_o = vld_q[5];
  assign res_o = res_q;

endmodule

@@ design/thin_multipole_kick.sv @@
// channel | dir | tdata (lsb up)                                   | tuser
// --------+-----+--------------------------------------------------+----------
// s_axis  | in  | pos_x, pos_y, slope_x, slope_y, momentum_ratio   | -
// m_axis  | out | new_slope_x, new_slope_y                         | saturated
// cfg     | in  | write enable, register index, write data         | -
//
// one beat per cycle sustained while the skid entry is free; a beat passes
// through the rotation stages, one three-stage power cell per order above one
// up to MAX_ORDER, the kick stages and the output register.
// reset clears all valid bits and loads the register reset values.
// an output register plus one skid entry let the chain advance while a result
// waits; tready drops only once the skid entry holds a beat.
module thin_multipole_kick
  import tmk_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x[31:0], pos_y[63:32], slope_x[95:64], slope_y[127:96],
  // momentum_ratio[158:128], zero pad[159]
  input  logic [159:0]                  s_axis_tdata,
  // master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // new_slope_x[31:0], new_slope_y[63:32]
  output logic [63:0]                   m_axis_tdata,
  // saturated[0]
  output logic                          m_axis_tuser,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_idx_i,
  input  logic [DATA_WIDTH-1:0]         cfg_wdata_i
);

  localparam int NCELL = MAX_ORDER - 1;

  // configuration registers
  data_t                  strength_cos_q, strength_sin_q, offset_x_q, offset_y_q;
  logic [TILT_WIDTH-1:0]  tilt_cos_q, tilt_sin_q;
  logic [ORDER_WIDTH-1:0] pole_order_q;

  logic [ORD_EXT_WIDTH-1:0] ord_ext, ord_eff;
  logic [NCELL-1:0]         cell_act;

  logic   en;
  carry_t carry_in;
  pow_t   chain_pl [NCELL+1];
  logic   chain_vld [NCELL+1];
  logic   res_vld;
  res_t   res;

  logic   out_vld_q, skid_vld_q;
  res_t   out_q, skid_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_cos_q <= '0;
      strength_sin_q <= '0;
      offset_x_q     <= '0;
      offset_y_q     <= '0;
      tilt_cos_q     <= TILT_COS_RST;
      tilt_sin_q     <= '0;
      pole_order_q   <= POLE_ORDER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STRENGTH_COS: strength_cos_q <= cfg_wdata_i;
        CFG_STRENGTH_SIN: strength_sin_q <= cfg_wdata_i;
        CFG_OFFSET_X:     offset_x_q     <= cfg_wdata_i;
        CFG_OFFSET_Y:     offset_y_q     <= cfg_wdata_i;
        CFG_TILT_COS:     tilt_cos_q     <= cfg_wdata_i[TILT_WIDTH-1:0];
        CFG_TILT_SIN:     tilt_sin_q     <= cfg_wdata_i[TILT_WIDTH-1:0];
        CFG_POLE_ORDER:   pole_order_q   <= cfg_wdata_i[ORDER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // clamp order to 1..MAX_ORDER and enable the cells below it
  assign ord_ext = {1'b0, pole_order_q};

  always_comb begin
    if (ord_ext == '0) begin
      ord_eff = ORD_EXT_WIDTH'(1);
    end else if (ord_ext > ORD_EXT_WIDTH'(MAX_ORDER)) begin
      ord_eff = ORD_EXT_WIDTH'(MAX_ORDER);
    end else begin
      ord_eff = ord_ext;
    end
    for (int k = 0; k < NCELL; k++) begin
      cell_act[k] = ord_eff > ORD_EXT_WIDTH'(k + 1);
    end
  end

  // whole chain moves while the skid entry is free
  assign en            = ~skid_vld_q;
  assign s_axis_tready = en;

  assign carry_in.sx    = s_axis_tdata[95:64];
  assign carry_in.sy    = s_axis_tdata[127:96];
  assign carry_in.ratio = s_axis_tdata[158:128];

  tmk_rotate u_rotate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (s_axis_tvalid),
    .pos_x_i    (s_axis_tdata[31:0]),
    .pos_y_i    (s_axis_tdata[63:32]),
    .carry_i    (carry_in),
    .offset_x_i (offset_x_q),
    .offset_y_i (offset_y_q),
    .tilt_cos_i (tilt_cos_q),
    .tilt_sin_i (tilt_sin_q),
    .vld_o      (chain_vld[0]),
    .pl_o       (chain_pl[0])
  );

  // one power cell per order step
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    tmk_pow_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .act_i  (cell_act[g]),
      .vld_i  (chain_vld[g]),
      .pl_i   (chain_pl[g]),
      .vld_o  (chain_vld[g+1]),
      .pl_o   (chain_pl[g+1])
    );
  end

  tmk_kick u_kick (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .vld_i          (chain_vld[NCELL]),
    .pl_i           (chain_pl[NCELL]),
    .strength_cos_i (strength_cos_q),
    .strength_sin_i (strength_sin_q),
    .vld_o          (res_vld),
    .res_o          (res)
  );

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= res_vld;
      end
    end else if (en && res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (en && res_vld) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.ny, out_q.nx};
  assign m_axis_tuser  = out_q.sat;

endmodule
